FILE: rtl/core/qbsp_pkg.sv
// qbsp_pkg: shared types and constants of the quadratic b-spline point generator
`timescale 1ns / 1ps

package qbsp_pkg;

  // basis weights are integers at this scale
  localparam int WSCALE    = 1000;
  localparam int WHALF     = WSCALE / 2;
  localparam int WCENTER   = 3 * WSCALE / 4;
  localparam int WTWICE    = 2 * WSCALE;
  localparam int W_W       = 10;

  localparam int OUT_W     = 13;
  localparam int OFF_W     = 12;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OFFSET_X = 1'b0,
    REG_OFFSET_Y = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_MOVE  = 4'b0010,
    ST_SEG   = 4'b0100,
    ST_CLOSE = 4'b1000
  } seq_state_e;

  // weights of one sample: t1 on the newest point, t3 on the oldest
  typedef struct packed {
    logic [W_W-1:0] t1;
    logic [W_W-1:0] t2;
    logic [W_W-1:0] t3;
  } weights_t;

endpackage

FILE: rtl/core/qbsp_if.sv
// qbsp_if: valid/ready channel interfaces for points, results and configuration
`timescale 1ns / 1ps

interface qbsp_point_if #(
  parameter int COORD_BITS = 12
) ();
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] point_x;
  logic [COORD_BITS-1:0] point_y;
  logic                  first_point;
  logic                  final_point;

  modport source (output valid, point_x, point_y, first_point, final_point, input ready);
  modport sink   (input valid, point_x, point_y, first_point, final_point, output ready);
endinterface

interface qbsp_result_if import qbsp_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] out_x;
  logic [OUT_W-1:0] out_y;
  logic             pen_move;
  logic             run_end;

  modport source (output valid, out_x, out_y, pen_move, run_end, input ready);
  modport sink   (input valid, out_x, out_y, pen_move, run_end, output ready);
endinterface

interface qbsp_cfg_if import qbsp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [OFF_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/qbsp_blend.sv
// qbsp_blend: weighted sum of three control coordinates plus rounding bias
`timescale 1ns / 1ps

module qbsp_blend import qbsp_pkg::*; #(
  parameter int COORD_BITS = 12
) (
  input  weights_t                     w_i,
  input  logic [COORD_BITS-1:0]        a_i,
  input  logic [COORD_BITS-1:0]        b_i,
  input  logic [COORD_BITS-1:0]        c_i,
  output logic [COORD_BITS+W_W-1:0]    sum_o
);

  localparam int SUM_W = COORD_BITS + W_W;

  // weights never sum above the scale, so the sum stays below 1024 * 2^COORD_BITS
  assign sum_o = SUM_W'(w_i.t1) * SUM_W'(c_i)
               + SUM_W'(w_i.t2) * SUM_W'(b_i)
               + SUM_W'(w_i.t3) * SUM_W'(a_i)
               + SUM_W'(WHALF);

endmodule

FILE: rtl/core/quadratic_bspline_point_generator_top.sv
// quadratic_bspline_point_generator_top: uniform quadratic b-spline point generator
`timescale 1ns / 1ps

// channel   modport  payload                                    role
// cfg_i     sink     index, data                                offset register writes
// point_i   sink     point_x, point_y, first_point, final_point control point requests
// result_o  source   out_x, out_y, pen_move, run_end            generated points
//
// one result leaves per cycle while result_o is ready; a request issues 1 (first),
// STEPS (later), STEPS+1 (first and final) or 2*STEPS (later and final) samples to the blend
// datapath, one sample per cycle unless stalled, then through the blend and output registers;
// the next request is taken in the cycle the previous one issues its last sample
// reset clears state, offsets and valid flags at once; no clearing pass
// a stall on result_o freezes the whole pipeline; cfg_i is always ready

module quadratic_bspline_point_generator_top import qbsp_pkg::*; #(
  parameter int STEPS      = 10,
  parameter int COORD_BITS = 12
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  qbsp_cfg_if.sink      cfg_i,
  qbsp_point_if.sink    point_i,
  qbsp_result_if.source result_o
);

  localparam int J_W    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int SUM_W  = COORD_BITS + W_W;
  // exact divide by the scale: ceil(2^DIV_SH / scale), error below one lsb for SUM_W-bit sums
  localparam int DIV_SH = SUM_W + W_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << DIV_SH) + 64'(WSCALE - 1)) / 64'(WSCALE);
  localparam logic [SUM_W:0] RECIP = (SUM_W+1)'(RECIP_L);
  localparam int PROD_W = 2 * SUM_W + 1;
  localparam int ADD_W  = COORD_BITS + OUT_W;
  localparam logic [J_W-1:0] J_LAST = J_W'(STEPS - 1);

  // basis weight table, one entry per step of a segment
  logic [W_W-1:0] t1_tab [STEPS];
  logic [W_W-1:0] t2_tab [STEPS];
  logic [W_W-1:0] t3_tab [STEPS];

  for (genvar g = 0; g < STEPS; g++) begin : g_wt
    localparam int WJ = WSCALE * g / STEPS;
    localparam int T1 = WJ * WJ / WTWICE;
    localparam int T2 = WCENTER - (WJ - WHALF) * (WJ - WHALF) / WSCALE;
    localparam int T3 = (WJ - WSCALE) * (WJ - WSCALE) / WTWICE;
    assign t1_tab[g] = W_W'(T1);
    assign t2_tab[g] = W_W'(T2);
    assign t3_tab[g] = W_W'(T3);
  end

  // offset registers
  logic [OFF_W-1:0] offset_x_q, offset_y_q;

  // sequencer: state, step counter and the three control points of the current request
  seq_state_e            state_q, state_d;
  logic [J_W-1:0]        j_q, j_d;
  logic                  final_q;
  logic [COORD_BITS-1:0] oldest_x_q, oldest_y_q;
  logic [COORD_BITS-1:0] older_x_q, older_y_q;
  logic [COORD_BITS-1:0] newer_x_q, newer_y_q;

  // blend stage and output register
  logic                  p1_valid_q;
  logic [SUM_W-1:0]      p1_sx_q, p1_sy_q;
  logic                  p1_move_q, p1_end_q;
  logic                  out_valid_q;
  logic [OUT_W-1:0]      out_x_q, out_y_q;
  logic                  out_move_q, out_end_q;

  logic                  adv, issue, step_end, last_issue, in_ready, in_fire;
  weights_t              w;
  logic [COORD_BITS-1:0] sel_ax, sel_ay, sel_bx, sel_by;
  logic [SUM_W-1:0]      sum_x, sum_y;
  logic [PROD_W-1:0]     prod_x, prod_y;
  logic [COORD_BITS-1:0] q_x, q_y;

  // config writes, taken every cycle
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q <= '0;
      offset_y_q <= '0;
    end else if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_OFFSET_X: offset_x_q <= cfg_i.data;
        REG_OFFSET_Y: offset_y_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // pipeline moves when the output register is empty or being drained
  assign adv = !out_valid_q || result_o.ready;

  always_comb begin
    issue      = (state_q != ST_IDLE);
    step_end   = (state_q == ST_MOVE) || (j_q == J_LAST);
    // the close segment always ends a request; move or segment only when not final
    last_issue = issue && step_end && ((state_q == ST_CLOSE) || !final_q);
    in_ready   = (state_q == ST_IDLE) || (adv && last_issue);
    in_fire    = point_i.valid && in_ready;

    state_d = state_q;
    j_d     = j_q;
    if (in_fire) begin
      state_d = point_i.first_point ? ST_MOVE : ST_SEG;
      j_d     = '0;
    end else if (adv && issue) begin
      if (last_issue) begin
        state_d = ST_IDLE;
        j_d     = '0;
      end else if (step_end) begin
        state_d = ST_CLOSE;
        j_d     = '0;
      end else begin
        j_d = j_q + 1'b1;
      end
    end
  end

  assign point_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      j_q        <= '0;
      final_q    <= 1'b0;
      oldest_x_q <= '0;
      oldest_y_q <= '0;
      older_x_q  <= '0;
      older_y_q  <= '0;
      newer_x_q  <= '0;
      newer_y_q  <= '0;
    end else begin
      state_q <= state_d;
      j_q     <= j_d;
      if (in_fire) begin
        final_q <= point_i.final_point;
        // a first point fills all slots, a later one shifts in
        if (point_i.first_point) begin
          oldest_x_q <= point_i.point_x;
          oldest_y_q <= point_i.point_y;
          older_x_q  <= point_i.point_x;
          older_y_q  <= point_i.point_y;
        end else begin
          oldest_x_q <= older_x_q;
          oldest_y_q <= older_y_q;
          older_x_q  <= newer_x_q;
          older_y_q  <= newer_y_q;
        end
        newer_x_q <= point_i.point_x;
        newer_y_q <= point_i.point_y;
      end
    end
  end

  // sample weights; a move uses full weight on the newest point
  always_comb begin
    case (state_q)
      ST_MOVE:           w = '{t1: W_W'(WSCALE), t2: '0, t3: '0};
      ST_SEG, ST_CLOSE:  w = '{t1: t1_tab[j_q], t2: t2_tab[j_q], t3: t3_tab[j_q]};
      default:           w = '0;
    endcase
  end

  // closing segment runs over (older, newer, newer), doubling the end point
  assign sel_ax = (state_q == ST_CLOSE) ? older_x_q : oldest_x_q;
  assign sel_ay = (state_q == ST_CLOSE) ? older_y_q : oldest_y_q;
  assign sel_bx = (state_q == ST_CLOSE) ? newer_x_q : older_x_q;
  assign sel_by = (state_q == ST_CLOSE) ? newer_y_q : older_y_q;

  qbsp_blend #(.COORD_BITS(COORD_BITS)) u_blend_x (
    .w_i   (w),
    .a_i   (sel_ax),
    .b_i   (sel_bx),
    .c_i   (newer_x_q),
    .sum_o (sum_x)
  );

  qbsp_blend #(.COORD_BITS(COORD_BITS)) u_blend_y (
    .w_i   (w),
    .a_i   (sel_ay),
    .b_i   (sel_by),
    .c_i   (newer_y_q),
    .sum_o (sum_y)
  );

  // divide by the scale through the reciprocal, then add the offset
  assign prod_x = PROD_W'(p1_sx_q) * PROD_W'(RECIP);
  assign prod_y = PROD_W'(p1_sy_q) * PROD_W'(RECIP);
  assign q_x    = prod_x[DIV_SH +: COORD_BITS];
  assign q_y    = prod_y[DIV_SH +: COORD_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      p1_valid_q  <= issue;
      out_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_sx_q    <= sum_x;
      p1_sy_q    <= sum_y;
      p1_move_q  <= (state_q == ST_MOVE);
      p1_end_q   <= last_issue;
      out_x_q    <= OUT_W'(ADD_W'(q_x) + ADD_W'(offset_x_q));
      out_y_q    <= OUT_W'(ADD_W'(q_y) + ADD_W'(offset_y_q));
      out_move_q <= p1_move_q;
      out_end_q  <= p1_end_q;
    end
  end

  assign result_o.valid    = out_valid_q;
  assign result_o.out_x    = out_x_q;
  assign result_o.out_y    = out_y_q;
  assign result_o.pen_move = out_move_q;
  assign result_o.run_end  = out_end_q;

`ifndef NO_ASSERTIONS
  // step counter never runs past the last step of a segment
  assert property (@(posedge clk_i) disable iff (!rst_ni) j_q <= J_LAST)
    else $error("step counter out of range");

  // a first point always starts with its move result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && point_i.first_point) |=> (state_q == ST_MOVE))
    else $error("first point did not start with a move");

  // no new request while a segment is mid-run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_SEG) && (j_q != J_LAST)) |-> !point_i.ready)
    else $error("request taken mid-segment");

  // issued weights never sum above the scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |-> ((12'(w.t1) + 12'(w.t2) + 12'(w.t3)) <= 12'(WSCALE)))
    else $error("weight sum above scale");
`endif

endmodule
